@@ hdl/rgbfade_pkg.sv @@
// rgbfade_pkg: payload types, codes and color-stop constants for the
// rgb color-stop fade sequencer. No dependencies.
package rgbfade_pkg;

   localparam int DUR_W  = 16;
   localparam int TIME_W = 20;
   localparam int CHAN_W = 8;
   localparam int NUM_W  = 24;

   localparam logic [DUR_W-1:0]  BLACK_RESET = 16'd30000;
   localparam logic [TIME_W-1:0] CYCLE_MAX   = 20'hFFFFF;

   // item function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic              func;
      logic [3:0]        entry_index;
      logic [DUR_W-1:0]  duration_ms;
      logic [TIME_W-1:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              in_black_phase;
      logic              past_end;
      logic [TIME_W-1:0] cycle_length;
   } rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   localparam rgb_type RGB_BLACK = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
   localparam rgb_type RGB_WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255};

   // first eight color stops
   function automatic rgb_type stop_lut(input logic [2:0] k);
      rgb_type c;
      case (k)
         3'd0: c = RGB_BLACK;
         3'd1: c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
         3'd2: c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
         3'd3: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
         3'd4: c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
         3'd5: c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
         3'd6: c = '{red: 8'd128, green: 8'd0,   blue: 8'd128};
         3'd7: c = RGB_WHITE;
         default: c = RGB_BLACK;
      endcase
      return c;
   endfunction

   // level * x by shift and add; stop levels are only 0, 128 and 255
   function automatic logic [NUM_W-1:0] level_scale(input logic [CHAN_W-1:0] level,
                                                   input logic [DUR_W-1:0] x);
      logic [NUM_W-1:0] r;
      case (level)
         8'd255:  r = {x, 8'b0} - {8'b0, x};
         8'd128:  r = {1'b0, x, 7'b0};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/rgb_color_stop_fade_sequencer_top.sv @@
// rgb_color_stop_fade_sequencer_top: duration table memory, segment walk and
// blend divider. Depends on rgbfade_pkg.
//
// Color-stop fade sequencer. A write item (func 0) with an in-range index
// stores one duration in the table and answers with the new cycle length.
// A query (func 1) returns the color at time_ms: in the black phase it goes
// straight to the result register, else the table is walked one entry per
// cycle through its single read port, and a hit in a fade goes on through the
// numerator and the 8-step restoring divider that runs the three color
// channels side by side before the result register is loaded. One item
// is in work at a time; a new item is taken as soon as the previous result
// is loaded into the output register, even while it waits to be taken.
// The black phase length is written on the csr port, which is always ready.
module rgb_color_stop_fade_sequencer_top #(
   parameter int FADE_SEGMENTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rgbfade_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rgbfade_pkg::rsp_type rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_data
);

   localparam int ENTRY_COUNT = 2 * FADE_SEGMENTS - 1;
   localparam int AW = $clog2(ENTRY_COUNT + 1);
   localparam int KW = $clog2(FADE_SEGMENTS + 1);
   localparam int SW = $clog2(ENTRY_COUNT) + rgbfade_pkg::DUR_W;
   localparam int TW = (SW + 1 > rgbfade_pkg::TIME_W + 1) ? SW + 1 : rgbfade_pkg::TIME_W + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_WR_UPD, S_WALK, S_NUM, S_DIV, S_RESULT
   } state_type;

   state_type state_ff;

   // stop color k of the sequence, black from the last stop on
   function automatic rgbfade_pkg::rgb_type stop_color(input logic [KW-1:0] k);
      int ki;
      ki = int'(k);
      if (ki >= FADE_SEGMENTS) return rgbfade_pkg::RGB_BLACK;
      else if (ki > 7) return rgbfade_pkg::RGB_WHITE;
      else return rgbfade_pkg::stop_lut(3'(ki));
   endfunction

   // duration table memory
   logic [rgbfade_pkg::DUR_W-1:0] dur_mem [ENTRY_COUNT];
   logic [rgbfade_pkg::DUR_W-1:0] rd_data_ff;
   logic                          rd_vld_ff;
   logic [ENTRY_COUNT-1:0]        vld_ff;
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   logic                          wr_en;

   // item registers
   logic [AW-1:0]                 addr_ff;
   logic [rgbfade_pkg::DUR_W-1:0] dur_w_ff;
   logic [15:0]                   black_ff;
   logic [SW-1:0]                 sum_ff;
   logic [SW-1:0]                 sum_in;

   // walk registers
   logic [rgbfade_pkg::TIME_W-1:0] ms_ff;
   logic [AW-1:0]                  iss_step_ff;
   logic [AW-1:0]                  cmp_step_ff;
   logic                           pend_ff;
   logic [rgbfade_pkg::DUR_W-1:0]  dur_q;
   logic [KW-1:0]                  seg;

   // blend lanes
   logic [rgbfade_pkg::DUR_W-1:0]  d_ff;
   logic [rgbfade_pkg::DUR_W-1:0]  diff_ff;
   logic [rgbfade_pkg::CHAN_W-1:0] lvl_a_ff [3];
   logic [rgbfade_pkg::CHAN_W-1:0] lvl_b_ff [3];
   logic [rgbfade_pkg::NUM_W-1:0]  rem_ff [3];
   logic [rgbfade_pkg::NUM_W-1:0]  rem_in [3];
   logic [rgbfade_pkg::CHAN_W-1:0] quo_ff [3];
   logic [rgbfade_pkg::CHAN_W-1:0] quo_in [3];
   logic [rgbfade_pkg::NUM_W-1:0]  num_in [3];
   logic [2:0]                     bit_ff;

   // result registers
   rgbfade_pkg::rgb_type color_ff;
   logic                 black_flag_ff;
   logic                 past_flag_ff;
   logic                 rsp_valid_ff;
   rgbfade_pkg::rsp_type rsp_ff;

   logic                          req_idx_ok;
   logic [TW-1:0]                 total_in;
   logic [rgbfade_pkg::TIME_W-1:0] cycle_len_in;
   rgbfade_pkg::rgb_type          stop_a;
   rgbfade_pkg::rgb_type          stop_b;

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign req_idx_ok = 32'(req_payload.entry_index) < 32'(ENTRY_COUNT);
   assign dur_q      = rd_vld_ff ? rd_data_ff : '0;
   assign wr_en      = (state_ff == S_WR_UPD);
   assign sum_in     = sum_ff + SW'(dur_w_ff) - SW'(dur_q);
   assign seg        = KW'(cmp_step_ff >> 1);
   assign stop_a     = stop_color(seg);
   assign stop_b     = stop_color(seg + KW'(1));

   // cycle length, saturated
   assign total_in     = TW'(black_ff) + TW'(sum_ff);
   assign cycle_len_in = (total_in > TW'(rgbfade_pkg::CYCLE_MAX)) ?
                         rgbfade_pkg::CYCLE_MAX : total_in[rgbfade_pkg::TIME_W-1:0];

   // read port: entry of the incoming item, or the next walk step
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (state_ff == S_IDLE && req_valid && req_idx_ok) begin
         rd_en   = 1'b1;
         rd_addr = AW'(req_payload.entry_index);
      end else if (state_ff == S_WALK && iss_step_ff < AW'(ENTRY_COUNT)) begin
         rd_en   = 1'b1;
         rd_addr = iss_step_ff[0] ? AW'(FADE_SEGMENTS) + (iss_step_ff >> 1)
                                  : (iss_step_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) dur_mem[addr_ff] <= dur_w_ff;
      if (rd_en) rd_data_ff <= dur_mem[rd_addr];
   end

   // blend numerator and one restoring divide step per lane
   always_comb begin
      logic [rgbfade_pkg::NUM_W-1:0] shifted;
      logic [rgbfade_pkg::NUM_W:0]   trial;
      for (int l = 0; l < 3; l++) begin
         num_in[l] = rgbfade_pkg::level_scale(lvl_a_ff[l], diff_ff)
                   + rgbfade_pkg::level_scale(lvl_b_ff[l], ms_ff[rgbfade_pkg::DUR_W-1:0])
                   + {9'b0, d_ff[rgbfade_pkg::DUR_W-1:1]};
         shifted   = {8'b0, d_ff} << bit_ff;
         trial     = {1'b0, rem_ff[l]} - {1'b0, shifted};
         if (!trial[rgbfade_pkg::NUM_W]) begin
            rem_in[l] = trial[rgbfade_pkg::NUM_W-1:0];
            quo_in[l] = quo_ff[l] | (8'b1 << bit_ff);
         end else begin
            rem_in[l] = rem_ff[l];
            quo_in[l] = quo_ff[l];
         end
      end
   end

   // sequencer, table valid bits and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         black_ff     <= rgbfade_pkg::BLACK_RESET;
         sum_ff       <= '0;
         vld_ff       <= '0;
         pend_ff      <= 1'b0;
      end else begin
         if (csr_valid) black_ff <= csr_data;
         // result item taken, unless the next one loads in its place
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESULT) rsp_valid_ff <= 1'b0;
         if (rd_en) rd_vld_ff <= vld_ff[rd_addr];

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  addr_ff       <= AW'(req_payload.entry_index);
                  dur_w_ff      <= req_payload.duration_ms;
                  color_ff      <= rgbfade_pkg::RGB_BLACK;
                  black_flag_ff <= 1'b0;
                  past_flag_ff  <= 1'b0;
                  if (req_payload.func == rgbfade_pkg::FUNC_WRITE) begin
                     state_ff <= req_idx_ok ? S_WR_UPD : S_RESULT;
                  end else if (req_payload.time_ms < {4'b0, black_ff}) begin
                     black_flag_ff <= 1'b1;
                     state_ff      <= S_RESULT;
                  end else begin
                     ms_ff       <= req_payload.time_ms - {4'b0, black_ff};
                     iss_step_ff <= '0;
                     pend_ff     <= 1'b0;
                     state_ff    <= S_WALK;
                  end
               end
            end
            // old entry value is in the read register now
            S_WR_UPD: begin
               sum_ff          <= sum_in;
               vld_ff[addr_ff] <= 1'b1;
               state_ff        <= S_RESULT;
            end
            // one table entry compared per cycle, next read already issued
            S_WALK: begin
               pend_ff     <= rd_en;
               cmp_step_ff <= iss_step_ff;
               if (rd_en) iss_step_ff <= iss_step_ff + AW'(1);
               if (pend_ff) begin
                  if (ms_ff < rgbfade_pkg::TIME_W'(dur_q)) begin
                     if (!cmp_step_ff[0]) begin
                        d_ff        <= dur_q;
                        diff_ff     <= dur_q - ms_ff[rgbfade_pkg::DUR_W-1:0];
                        lvl_a_ff[0] <= stop_a.red;
                        lvl_a_ff[1] <= stop_a.green;
                        lvl_a_ff[2] <= stop_a.blue;
                        lvl_b_ff[0] <= stop_b.red;
                        lvl_b_ff[1] <= stop_b.green;
                        lvl_b_ff[2] <= stop_b.blue;
                        state_ff    <= S_NUM;
                     end else begin
                        color_ff <= stop_b;
                        state_ff <= S_RESULT;
                     end
                  end else begin
                     ms_ff <= ms_ff - rgbfade_pkg::TIME_W'(dur_q);
                     if (cmp_step_ff == AW'(ENTRY_COUNT - 1)) begin
                        past_flag_ff <= 1'b1;
                        state_ff     <= S_RESULT;
                     end
                  end
               end
            end
            S_NUM: begin
               for (int l = 0; l < 3; l++) begin
                  rem_ff[l] <= num_in[l];
                  quo_ff[l] <= '0;
               end
               bit_ff   <= 3'd7;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               for (int l = 0; l < 3; l++) begin
                  rem_ff[l] <= rem_in[l];
                  quo_ff[l] <= quo_in[l];
               end
               bit_ff <= bit_ff - 3'd1;
               if (bit_ff == 3'd0) begin
                  color_ff.red   <= quo_in[0];
                  color_ff.green <= quo_in[1];
                  color_ff.blue  <= quo_in[2];
                  state_ff       <= S_RESULT;
               end
            end
            // load the output register once it is free
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.red            <= color_ff.red;
                  rsp_ff.green          <= color_ff.green;
                  rsp_ff.blue           <= color_ff.blue;
                  rsp_ff.in_black_phase <= black_flag_ff;
                  rsp_ff.past_end       <= past_flag_ff;
                  rsp_ff.cycle_length   <= cycle_len_in;
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ hdl/rgbfade_check.sv @@
// rgbfade_check: port-level checks for the rgb color-stop fade sequencer,
// bound to the top level. Depends on rgbfade_pkg.
module rgbfade_check (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input rgbfade_pkg::req_type req_payload,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rgbfade_pkg::rsp_type rsp_payload
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous one in work");

   // black phase and past end exclude each other
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.in_black_phase && rsp_payload.past_end))
      else $error("both black phase and past end set");

   // black phase and past end give black
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.in_black_phase || rsp_payload.past_end) |->
         rsp_payload.red == 8'd0 && rsp_payload.green == 8'd0 &&
         rsp_payload.blue == 8'd0)
      else $error("color not black outside the fade segments");

endmodule

bind rgb_color_stop_fade_sequencer_top rgbfade_check u_rgbfade_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
